### design/ukt_pkg.sv
`default_nettype none

package ukt_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int PAY_W    = 64;
  localparam int ENTRY_W  = KEY_W + PAY_W;
  localparam int COUNT_FIELD_W = 7;

  // request queue between front and back, depth is a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_BAD    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [KEY_W-1:0] entry_key;
    logic [PAY_W-1:0]        entry_payload;
  } in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [PAY_W-1:0]         found_payload;
    logic [COUNT_FIELD_W-1:0] occupied_count;
    logic [COUNT_FIELD_W-1:0] free_count;
  } out_t;

  typedef struct packed {
    op_t                     op;
    logic signed [KEY_W-1:0] entry_key;
    logic [PAY_W-1:0]        entry_payload;
  } req_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } entry_t;

  // low bits of a count, zero extended when the count is narrower
  function automatic logic [COUNT_FIELD_W-1:0] count_field(input logic [CNT_W-1:0] c);
    logic [CNT_W+COUNT_FIELD_W-1:0] w;
    w = {{COUNT_FIELD_W{1'b0}}, c};
    return w[COUNT_FIELD_W-1:0];
  endfunction

  function automatic out_t make_result(input status_t st, input logic [PAY_W-1:0] pay,
                                       input logic [CNT_W-1:0] cnt);
    out_t r;
    logic [CNT_W-1:0] free_cnt;
    free_cnt = CNT_W'(CAPACITY) - cnt;
    r.status         = st;
    r.found_payload  = pay;
    r.occupied_count = count_field(cnt);
    r.free_count     = count_field(free_cnt);
    return r;
  endfunction

endpackage

`default_nettype wire

### design/ukt_ram.sv
`default_nettype none

module ukt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/ukt_front.sv
`default_nettype none

module ukt_front import ukt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      req_valid,
  output req_t      req,
  input  wire logic req_pop
);

  req_t              q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              push;
  req_t              classified;

  assign in_stall  = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign push      = in_valid && !in_stall;
  assign req_valid = (fill != '0);
  assign req       = q[rd_ptr];

  always_comb begin
    classified.entry_key     = in_data.entry_key;
    classified.entry_payload = in_data.entry_payload;
    unique case (in_data.cmd)
      CMD_INSERT: classified.op = OP_INSERT;
      CMD_REMOVE: classified.op = OP_REMOVE;
      CMD_LOOKUP: classified.op = OP_LOOKUP;
      default:    classified.op = OP_BAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (req_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, req_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/ukt_back.sv
`default_nettype none

module ukt_back import ukt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  input  wire req_t req,
  output logic      req_pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    MOVE,
    MOVE_WR
  } state_t;

  state_t           state;
  req_t             cur;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_m1;
  logic [CNT_W-1:0] scan_addr;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] last_idx;
  logic             rd_pending;
  logic             hit;
  logic             scan_end;
  logic             issue;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;
  entry_t             new_entry;

  ukt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_entry  = entry_t'(ram_rdata);
  assign count_m1  = count - 1'b1;
  assign last_idx  = count_m1[IDX_W-1:0];
  assign hit       = rd_pending && (rd_entry.key == cur.entry_key);
  assign scan_end  = rd_pending && (rd_idx == last_idx);
  assign issue     = (state == SCAN) && !hit && (scan_addr < count);
  assign req_pop   = (state == IDLE) && req_valid && !out_valid;

  always_comb begin
    new_entry.key     = req.entry_key;
    new_entry.payload = req.entry_payload;
    ram_we    = (req_pop && (req.op == OP_INSERT) && (count != CNT_W'(CAPACITY)))
                || (state == MOVE_WR);
    ram_waddr = (state == MOVE_WR) ? hit_idx : count[IDX_W-1:0];
    ram_wdata = (state == MOVE_WR) ? ram_rdata : ENTRY_W'(new_entry);
    // move reads the last entry, scan walks the table from slot zero
    ram_raddr = (state == MOVE) ? last_idx : scan_addr[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      count      <= '0;
      out_valid  <= 1'b0;
      rd_pending <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      rd_pending <= issue;
      rd_idx     <= scan_addr[IDX_W-1:0];
      unique case (state)
        IDLE: begin
          if (req_pop) begin
            cur       <= req;
            scan_addr <= '0;
            unique case (req.op)
              OP_INSERT: begin
                out_valid <= 1'b1;
                if (count == CNT_W'(CAPACITY)) begin
                  out_data <= make_result(ST_FULL, '0, count);
                end else begin
                  count    <= count + 1'b1;
                  out_data <= make_result(ST_OK, '0, count + 1'b1);
                end
              end
              OP_REMOVE, OP_LOOKUP: begin
                if (count == '0) begin
                  out_valid <= 1'b1;
                  out_data  <= make_result(ST_MISS, '0, count);
                end else begin
                  state <= SCAN;
                end
              end
              OP_BAD: begin
                out_valid <= 1'b1;
                out_data  <= make_result(ST_MISS, '0, count);
              end
            endcase
          end
        end
        SCAN: begin
          if (issue) begin
            scan_addr <= scan_addr + 1'b1;
          end
          priority if (hit) begin
            if (cur.op == OP_LOOKUP) begin
              out_valid <= 1'b1;
              out_data  <= make_result(ST_OK, rd_entry.payload, count);
              state     <= IDLE;
            end else begin
              hit_idx <= rd_idx;
              state   <= MOVE;
            end
          end else if (scan_end) begin
            out_valid <= 1'b1;
            out_data  <= make_result(ST_MISS, '0, count);
            state     <= IDLE;
          end else begin
            // still waiting on read data
          end
        end
        MOVE: begin
          state <= MOVE_WR;
        end
        MOVE_WR: begin
          count     <= count_m1;
          out_valid <= 1'b1;
          out_data  <= make_result(ST_OK, '0, count_m1);
          state     <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### design/unordered_keyed_table_top.sv
`default_nettype none

// channel   valid      stall      payload
// request   in_valid   in_stall   in_data  (cmd, entry_key, entry_payload)
// result    out_valid  out_stall  out_data (status, found_payload, counts)
//
// insert writes the store directly from idle; lookup and remove scan the store one
// slot per cycle through the single read port, from slot zero up to a hit or the
// last entry; a remove hit then reads the last entry and moves it into the hit slot.
// the back end works on one request at a time; a two-entry request queue keeps
// taking requests while the back end scans or a result waits.
// synchronous reset empties the table and the queue; no clearing pass is needed.

module unordered_keyed_table_top import ukt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  logic req_valid;
  logic req_pop;
  req_t req;

  ukt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .req_valid(req_valid),
    .req      (req),
    .req_pop  (req_pop)
  );

  ukt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req      (req),
    .req_pop  (req_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

### bench/unordered_keyed_table_top_tb.sv
`timescale 1ns / 1ps

module unordered_keyed_table_top_tb;
  import ukt_pkg::*;

  localparam int RANDOM_REQUESTS = 450;
  localparam int DRAIN_CYCLES    = CAPACITY + 8;
  localparam int IDLE_LIMIT      = 20 * (CAPACITY + 4 + 20);

  class table_tracker;
    logic [KEY_W-1:0] keys [CAPACITY];
    logic [PAY_W-1:0] pays [CAPACITY];
    int held;
    int failures;
    out_t expected_results[$];

    function new();
      held = 0;
      failures = 0;
    endfunction

    function void note_request(in_t req);
      out_t want;
      status_t st;
      logic [PAY_W-1:0] hit_pay;
      int slot;
      st = ST_MISS;
      hit_pay = '0;
      slot = -1;
      // walk downward so the lowest matching slot wins
      for (int i = held - 1; i >= 0; i--) begin
        if (keys[i] == req.entry_key) slot = i;
      end
      case (req.cmd)
        OP_INSERT: begin
          if (held == CAPACITY) begin
            st = ST_FULL;
          end else begin
            keys[held] = req.entry_key;
            pays[held] = req.entry_payload;
            held++;
            st = ST_OK;
          end
        end
        OP_REMOVE: begin
          if (slot >= 0) begin
            held--;
            keys[slot] = keys[held];
            pays[slot] = pays[held];
            st = ST_OK;
          end
        end
        OP_LOOKUP: begin
          if (slot >= 0) begin
            hit_pay = pays[slot];
            st = ST_OK;
          end
        end
        default: begin
        end
      endcase
      want.status         = st;
      want.found_payload  = hit_pay;
      want.occupied_count = COUNT_FIELD_W'(held);
      want.free_count     = COUNT_FIELD_W'(CAPACITY - held);
      expected_results.push_back(want);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_results.size() == 0) begin
        $error("result with no request pending: %h", got);
        failures++;
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        failures++;
      end
      if (got.found_payload !== want.found_payload) begin
        $error("found_payload: expected %h, actual %h", want.found_payload, got.found_payload);
        failures++;
      end
      if (got.occupied_count !== want.occupied_count) begin
        $error("occupied_count: expected %0d, actual %0d", want.occupied_count,
               got.occupied_count);
        failures++;
      end
      if (got.free_count !== want.free_count) begin
        $error("free_count: expected %0d, actual %0d", want.free_count, got.free_count);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  logic send_quiet = 1'b0;
  int   idle_cycles = 0;

  table_tracker tracker = new();

  unordered_keyed_table_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) tracker.check_result(out_data);
      if (in_valid && !in_stall) tracker.note_request(in_data);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random stall before each result, with quiet stretches
  initial begin
    int hold;
    int served;
    logic quiet;
    served = 0;
    quiet = 1'b0;
    wait (!rst);
    forever begin
      if (served % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      hold = quiet ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      served++;
    end
  end

  function automatic in_t make_request(op_t op, logic [KEY_W-1:0] key,
                                       logic [PAY_W-1:0] pay);
    in_t req;
    req.cmd           = op;
    req.entry_key     = key;
    req.entry_payload = pay;
    return req;
  endfunction

  // keys mostly from a small pool so lookups and removes hit
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] pool [8];
    pool = '{32'h0, 32'h1, 32'h2, 32'h3, 32'h7fff_ffff, 32'h8000_0000,
             32'hffff_ffff, 32'h0000_1234};
    if ($urandom_range(0, 99) < 80) return pool[$urandom_range(0, 7)];
    return $urandom();
  endfunction

  task automatic send_request(input in_t req);
    int gap;
    gap = send_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    int bias;
    int pick;
    op_t op;
    logic [PAY_W-1:0] pay;
    bias = 50;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, unused code, extremes, duplicates, last-slot removal
    send_request(make_request(OP_LOOKUP, 32'h0, 64'h0));
    send_request(make_request(OP_REMOVE, 32'h0, 64'h0));
    send_request(make_request(OP_BAD, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff));
    send_request(make_request(OP_INSERT, 32'h8000_0000, 64'h0));
    send_request(make_request(OP_INSERT, 32'h7fff_ffff, 64'hffff_ffff_ffff_ffff));
    send_request(make_request(OP_INSERT, 32'h0, 64'h0123_4567_89ab_cdef));
    send_request(make_request(OP_INSERT, 32'hffff_ffff, 64'h8000_0000_0000_0001));
    send_request(make_request(OP_INSERT, 32'h0, 64'hdead_beef_cafe_f00d));
    send_request(make_request(OP_LOOKUP, 32'h0, 64'hffff_ffff_ffff_ffff));
    send_request(make_request(OP_LOOKUP, 32'h8000_0000, 64'h0));
    send_request(make_request(OP_LOOKUP, 32'h7fff_ffff, 64'h0));
    send_request(make_request(OP_LOOKUP, 32'h5, 64'h0));
    send_request(make_request(OP_REMOVE, 32'h5, 64'h0));
    send_request(make_request(OP_BAD, 32'h0, 64'hffff_ffff_ffff_ffff));
    send_request(make_request(OP_REMOVE, 32'h0, 64'h0));
    send_request(make_request(OP_LOOKUP, 32'h0, 64'h0));
    send_request(make_request(OP_REMOVE, 32'hffff_ffff, 64'h0));
    send_request(make_request(OP_REMOVE, 32'h8000_0000, 64'h0));
    send_request(make_request(OP_LOOKUP, 32'h7fff_ffff, 64'h0));
    send_request(make_request(OP_REMOVE, 32'h0, 64'h0));
    send_request(make_request(OP_REMOVE, 32'h7fff_ffff, 64'h0));
    send_request(make_request(OP_LOOKUP, 32'hffff_ffff, 64'h0));

    // random phases: insert-heavy, then remove-heavy, then mixed at random biases
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 60 == 0) begin
        if (n == 0) bias = 95;
        else if (n == 60) bias = 8;
        else begin
          pick = $urandom_range(0, 2);
          bias = (pick == 0) ? 95 : (pick == 1) ? 50 : 10;
        end
        send_quiet = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) op = OP_BAD;
      else if (pick < 3 + bias * 97 / 100) op = OP_INSERT;
      else op = $urandom_range(0, 1) ? OP_REMOVE : OP_LOOKUP;
      pay = {$urandom(), $urandom()};
      send_request(make_request(op, pick_key(), pay));
    end
    in_valid <= 1'b0;

    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.failures == 0 && tracker.expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
design/ukt_pkg.sv
design/ukt_ram.sv
design/ukt_front.sv
design/ukt_back.sv
design/unordered_keyed_table_top.sv
bench/unordered_keyed_table_top_tb.sv
